FILE: hdl/ulecm_pkg.sv
// ----------------------------------------------------------------------------
// ulecm_pkg
// Types and constants for the line echo block with LED command match.
// ----------------------------------------------------------------------------
package ulecm_pkg;

	localparam logic [7:0]  TERM_RESET = 8'd35;
	localparam logic [39:0] WORD_ON    = 40'h6C65646F6E;
	localparam logic [47:0] WORD_OFF   = 48'h6C65646F6666;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_ECHO   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_SEND = 3'b100
	} state_t;

endpackage

FILE: hdl/ulecm_ram.sv
// ----------------------------------------------------------------------------
// ulecm_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ulecm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: hdl/uart_line_echo_with_command_match_top.sv
// ----------------------------------------------------------------------------
// uart_line_echo_with_command_match_top
// Buffers received bytes into a line, echoes the line on the terminator and
// drives an LED from the words "ledon" and "ledoff" seen in the line.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  in       input      in_valid/in_stall   rx_byte
//  out      output     out_valid/out_stall kind, echo_byte, last_of_run,
//                                          led_on, line_discarded
//  cfg      input      cfg_valid/cfg_ready cfg_data (terminator)
//
// A stored, ignored or discarding byte is handled without leaving the idle
// state. On a terminator each buffered byte is first read from the line
// buffer RAM and then loaded into the output register. Reset clears the
// line and the LED state; the line buffer itself is not cleared. A stalled
// output holds the echo walk and the input channel.
// ----------------------------------------------------------------------------
module uart_line_echo_with_command_match_top
	import ulecm_pkg::*;
#(
	parameter int LINE_LIMIT = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [7:0] echo_byte,
	output logic       last_of_run,
	output logic       led_on,
	output logic       line_discarded,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	localparam int AW = $clog2(LINE_LIMIT);
	localparam int FW = $clog2(LINE_LIMIT + 1);

	state_t          state_q;
	logic [7:0]      term_q;
	logic [FW-1:0]   fill_q;
	logic [FW-1:0]   rd_idx_q;
	logic [47:0]     recent_q;
	logic            seen_on_q;
	logic            seen_off_q;
	logic            led_q;

	logic            out_valid_q;
	logic            kind_q;
	logic [7:0]      echo_byte_q;
	logic            last_q;
	logic            led_out_q;
	logic            disc_q;

	logic            out_free;
	logic            in_accept;
	logic            is_store;
	logic            is_discard;
	logic            is_echo;
	logic            is_status;
	logic [47:0]     recent_next;
	logic            seen_on_next;
	logic            seen_off_next;
	logic            led_next;
	logic            rd_en;
	logic [7:0]      rd_data;
	logic            send_now;
	logic            send_last;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || !out_free;
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		is_store   = 1'b0;
		is_discard = 1'b0;
		is_echo    = 1'b0;
		is_status  = 1'b0;
		if (in_accept && rx_byte != 8'd0) begin
			if (rx_byte != term_q && fill_q < FW'(LINE_LIMIT)) begin
				is_store = 1'b1;
			end else if (fill_q >= FW'(LINE_LIMIT)) begin
				is_discard = 1'b1;
			end else if (fill_q == '0) begin
				is_status = 1'b1;
			end else begin
				is_echo = 1'b1;
			end
		end
	end

	assign recent_next   = {recent_q[39:0], rx_byte};
	assign seen_on_next  = seen_on_q || (recent_next[39:0] == WORD_ON);
	assign seen_off_next = seen_off_q || (recent_next == WORD_OFF);
	assign led_next      = seen_off_next ? 1'b0 : (seen_on_next ? 1'b1 : led_q);

	assign rd_en     = (state_q == ST_READ);
	assign send_now  = (state_q == ST_SEND) && out_free;
	assign send_last = (rd_idx_q + FW'(1)) == fill_q;

	ulecm_ram #(
		.WIDTH (8),
		.DEPTH (LINE_LIMIT)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (is_store),
		.wr_addr (fill_q[AW-1:0]),
		.wr_data (rx_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			term_q     <= TERM_RESET;
			fill_q     <= '0;
			rd_idx_q   <= '0;
			recent_q   <= '0;
			seen_on_q  <= 1'b0;
			seen_off_q <= 1'b0;
			led_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				term_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (is_store) begin
						fill_q     <= fill_q + FW'(1);
						recent_q   <= recent_next;
						seen_on_q  <= seen_on_next;
						seen_off_q <= seen_off_next;
						led_q      <= led_next;
					end else if (is_discard) begin
						fill_q     <= '0;
						recent_q   <= '0;
						seen_on_q  <= 1'b0;
						seen_off_q <= 1'b0;
					end else if (is_echo) begin
						rd_idx_q <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (send_now) begin
						if (send_last) begin
							fill_q     <= '0;
							recent_q   <= '0;
							seen_on_q  <= 1'b0;
							seen_off_q <= 1'b0;
							state_q    <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q + FW'(1);
							state_q  <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (is_store || is_discard || is_status || send_now) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_store || is_discard || is_status) begin
			kind_q      <= KIND_STATUS;
			echo_byte_q <= 8'd0;
			last_q      <= 1'b1;
			led_out_q   <= is_store ? led_next : led_q;
			disc_q      <= is_discard;
		end else if (send_now) begin
			kind_q      <= KIND_ECHO;
			echo_byte_q <= rd_data;
			last_q      <= send_last;
			led_out_q   <= led_q;
			disc_q      <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign echo_byte      = echo_byte_q;
	assign last_of_run    = last_q;
	assign led_on         = led_out_q;
	assign line_discarded = disc_q;

endmodule
